// ===== rtl/core/gpfb_pkg.sv =====
package gpfb_pkg;

  localparam int PIXEL_WIDTH  = 128;
  localparam int PIXEL_HEIGHT = 32;
  localparam int PAGE_COUNT   = 4;

  localparam int STORE_DEPTH = PAGE_COUNT * PIXEL_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_LIMIT   = (PIXEL_HEIGHT < PAGE_COUNT * 8) ? PIXEL_HEIGHT : PAGE_COUNT * 8;

  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COUNT = 96;

  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam logic [7:0] GLYPH_LAST  = 8'd127;
  localparam logic [7:0] GLYPH_SUBST = 8'd63;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic read_sel;
    logic draw_sel;
    logic draw_wr;
    logic advance;
    logic out_fire;
  } gpfb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic draw_done;
    logic acc_ok;
  } gpfb_stat_t;

  localparam logic [7:0] FONT_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h08,8'h2A,8'h1C,8'h2A,8'h08}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h00,8'h08,8'h14,8'h22,8'h41}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h41,8'h22,8'h14,8'h08,8'h00}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h01,8'h01}, '{8'h3E,8'h41,8'h41,8'h51,8'h32},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h04,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h03,8'h04,8'h78,8'h04,8'h03},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h00,8'h7F,8'h41,8'h41},
    '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h41,8'h41,8'h7F,8'h00,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h08,8'h14,8'h54,8'h54,8'h3C},
    '{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
    '{8'h20,8'h40,8'h44,8'h3D,8'h00}, '{8'h00,8'h7F,8'h10,8'h28,8'h44},
    '{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
    '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7C},
    '{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
    '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
    '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
    '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
    '{8'h00,8'h00,8'h7F,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
    '{8'h08,8'h08,8'h2A,8'h1C,8'h08}, '{8'h08,8'h1C,8'h2A,8'h08,8'h08}
  };

  // bit n set when row page*8+n is on the panel
  function automatic logic [7:0] row_mask(input logic [3:0] page);
    logic [7:0] m;
    for (int n = 0; n < 8; n++) begin
      m[n] = (int'(page) * 8 + n) < ROW_LIMIT;
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/gpfb_ctrl.sv =====
module gpfb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          kind,
  input  gpfb_pkg::gpfb_stat_t stat,
  output gpfb_pkg::gpfb_cmd_t  cmd,
  output logic                busy
);
  import gpfb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_RD,
    S_OUT,
    S_DRAW_RD,
    S_DRAW_WR
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (kind_t'(kind))
            KIND_DRAW: state_nxt = S_DRAW_RD;
            KIND_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = S_CLR;
            end
            KIND_READ: state_nxt = S_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_RD: begin
        cmd.read_sel = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        cmd.out_fire = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DRAW_RD: begin
        cmd.draw_sel = 1'b1;
        if (stat.draw_done) begin
          state_nxt = S_IDLE;
        end else if (!stat.acc_ok) begin
          // lower page off the panel: skip that byte
          cmd.advance = 1'b1;
        end else begin
          state_nxt = S_DRAW_WR;
        end
      end
      S_DRAW_WR: begin
        cmd.draw_sel = 1'b1;
        cmd.draw_wr  = 1'b1;
        cmd.advance  = 1'b1;
        state_nxt    = S_DRAW_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // reset starts with a clearing pass over the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/core/gpfb_datapath.sv =====
module gpfb_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  gpfb_pkg::gpfb_cmd_t  cmd,
  input  logic [7:0]          col_pos,
  input  logic [5:0]          row_pos,
  input  logic [7:0]          char_code,
  input  logic [1:0]          read_page,
  input  logic [6:0]          read_column,
  output gpfb_pkg::gpfb_stat_t stat,
  output logic                out_valid,
  output logic [7:0]          out_read_byte
);
  import gpfb_pkg::*;

  logic [7:0]        mem [STORE_DEPTH];
  logic [7:0]        rdata_r;

  logic [7:0]        x_r;
  logic [5:0]        y_r;
  logic [6:0]        idx_r;
  logic [1:0]        rpage_r;
  logic [6:0]        rcol_r;
  logic [2:0]        k_r, k_nxt;
  logic              half_r, half_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [6:0]        code_idx;
  logic [8:0]        px;
  logic [2:0]        k_sel;
  logic [6:0]        col_bits;
  logic [14:0]       shifted;
  logic [3:0]        page;
  logic [7:0]        draw_mask;
  logic              rd_ok;
  logic [ADDR_W-1:0] draw_addr, read_addr, mem_addr;
  logic [7:0]        mem_wdata;
  logic              mem_we;

  always_comb begin
    if (char_code < GLYPH_FIRST || char_code > GLYPH_LAST) begin
      code_idx = 7'(GLYPH_SUBST - GLYPH_FIRST);
    end else begin
      code_idx = 7'(char_code - GLYPH_FIRST);
    end
  end

  assign px    = {1'b0, x_r} + {6'd0, k_r};
  assign k_sel = (int'(k_r) < GLYPH_COLS) ? k_r : 3'd0;
  assign col_bits = FONT_ROM[idx_r][k_sel][GLYPH_ROWS-1:0];
  assign shifted  = {8'd0, col_bits} << y_r[2:0];
  assign page     = {1'b0, y_r[5:3]} + {3'd0, half_r};
  assign draw_mask = (half_r ? {1'b0, shifted[14:8]} : shifted[7:0]) & row_mask(page);

  assign stat.draw_done = (int'(k_r) == GLYPH_COLS) || (int'(px) >= PIXEL_WIDTH);
  assign stat.acc_ok    = int'(page) < PAGE_COUNT;
  assign stat.clr_last  = (int'(clr_cnt_r) == STORE_DEPTH - 1);

  assign draw_addr = ADDR_W'(page) * ADDR_W'(PIXEL_WIDTH) + ADDR_W'(px);
  assign read_addr = ADDR_W'(rpage_r) * ADDR_W'(PIXEL_WIDTH) + ADDR_W'(rcol_r);
  assign rd_ok     = (int'(rpage_r) < PAGE_COUNT) && (int'(rcol_r) < PIXEL_WIDTH);

  always_comb begin
    if (cmd.clr_step) begin
      mem_addr = clr_cnt_r;
    end else if (cmd.draw_sel) begin
      mem_addr = draw_addr;
    end else if (cmd.read_sel) begin
      mem_addr = read_addr;
    end else begin
      mem_addr = clr_cnt_r;
    end
    mem_we    = cmd.clr_step | cmd.draw_wr;
    mem_wdata = cmd.clr_step ? 8'd0 : (rdata_r | draw_mask);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  always_comb begin
    k_nxt       = k_r;
    half_nxt    = half_r;
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.load) begin
      k_nxt    = 3'd0;
      half_nxt = 1'b0;
    end else if (cmd.advance) begin
      half_nxt = ~half_r;
      if (half_r) k_nxt = k_r + 3'd1;
    end
    if (cmd.clr_start) begin
      clr_cnt_nxt = '0;
    end else if (cmd.clr_step) begin
      clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= 3'd0;
      half_r    <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      k_r       <= k_nxt;
      half_r    <= half_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= col_pos;
      y_r     <= row_pos;
      idx_r   <= code_idx;
      rpage_r <= read_page;
      rcol_r  <= read_column;
    end
  end

  assign out_valid     = cmd.out_fire;
  assign out_read_byte = rd_ok ? rdata_r : 8'd0;

endmodule

// ===== rtl/core/glyph_to_page_framebuffer_unit.sv =====
// A read passes through states S_RD and S_OUT; the result is strobed in S_OUT.
// One item at a time: a new transfer is taken only while busy is low. A draw
// read-modify-writes each page byte of the glyph on the single store port, skips a byte
// below the panel and ends with a final check; a clear zeroes the whole store.
// Reset (synchronous, active low) runs a clearing pass over the store; busy stays high until it
// ends. The receiver cannot stall: results are one-cycle strobes.
module glyph_to_page_framebuffer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_col_pos,
  input  logic [5:0] in_row_pos,
  input  logic [7:0] in_char_code,
  input  logic [1:0] in_read_page,
  input  logic [6:0] in_read_column,
  output logic       out_valid,
  output logic [7:0] out_read_byte
);
  import gpfb_pkg::*;

  gpfb_cmd_t  cmd;
  gpfb_stat_t stat;
  logic       busy_int;

  assign busy = busy_int;

  gpfb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start & ~busy_int),
    .kind  (in_kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy_int)
  );

  gpfb_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .col_pos       (in_col_pos),
    .row_pos       (in_row_pos),
    .char_code     (in_char_code),
    .read_page     (in_read_page),
    .read_column   (in_read_column),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_read_byte (out_read_byte)
  );

endmodule

// ===== tb/glyph_to_page_framebuffer_unit_checker.sv =====
module glyph_to_page_framebuffer_unit_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_col_pos,
  input  logic [5:0] in_row_pos,
  input  logic [7:0] in_char_code,
  input  logic [1:0] in_read_page,
  input  logic [6:0] in_read_column,
  input  logic       out_valid,
  input  logic [7:0] out_read_byte,
  input  logic       end_check,
  output int         mismatch_count,
  output int         pending_reads
);
  import gpfb_pkg::*;

  // 5x7 font, glyph column 0 in the top byte, bit r of a column is glyph row r
  localparam logic [39:0] GLYPH_COLUMNS [96] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h00_08_14_22_41, 40'h14_14_14_14_14, 40'h41_22_14_08_00, 40'h02_01_51_09_06,
    40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01, 40'h3E_41_41_51_32,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
    40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_00_7F_41_41,
    40'h02_04_08_10_20, 40'h41_41_7F_00_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_14_54_54_3C,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h00_7F_10_28_44,
    40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
    40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h08_08_2A_1C_08, 40'h08_1C_2A_08_08
  };

  logic [7:0] frame_shadow [STORE_DEPTH];
  logic [7:0] expected_read_bytes [$];
  logic       leftovers_checked;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // OR one glyph into the shadow store, clipping at the right and bottom edges
  task automatic paint_glyph(input logic [7:0] x, input logic [5:0] y, input logic [7:0] code);
    int         glyph_idx;
    int         px;
    int         py;
    logic [7:0] column_bits;
    if (code < GLYPH_FIRST || code > GLYPH_LAST) begin
      glyph_idx = int'(GLYPH_SUBST) - int'(GLYPH_FIRST);
    end else begin
      glyph_idx = int'(code) - int'(GLYPH_FIRST);
    end
    for (int k = 0; k < 5; k++) begin
      px = int'(x) + k;
      if (px >= PIXEL_WIDTH) break;
      column_bits = GLYPH_COLUMNS[glyph_idx][39 - 8 * k -: 8];
      for (int r = 0; r < 7; r++) begin
        py = int'(y) + r;
        if (py >= PIXEL_HEIGHT || (py >> 3) >= PAGE_COUNT) break;
        if (column_bits[r]) begin
          frame_shadow[(py >> 3) * PIXEL_WIDTH + px][py & 7] = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      foreach (frame_shadow[i]) frame_shadow[i] = '0;
      expected_read_bytes.delete();
      mismatch_count = 0;
      leftovers_checked = 1'b0;
      pending_reads <= 0;
    end else begin
      // results come in order, so retire the strobe before queuing a new read
      if (out_valid) begin
        if (expected_read_bytes.size() == 0) begin
          report_mismatch($sformatf("read result %02h with no read outstanding",
                                    out_read_byte));
        end else begin
          want = expected_read_bytes.pop_front();
          if (out_read_byte !== want) begin
            report_mismatch($sformatf("read_byte got %02h expected %02h",
                                      out_read_byte, want));
          end
        end
      end
      if (start && !busy) begin
        case (in_kind)
          KIND_DRAW: paint_glyph(in_col_pos, in_row_pos, in_char_code);
          KIND_CLEAR: foreach (frame_shadow[i]) frame_shadow[i] = '0;
          KIND_READ: begin
            want = '0;
            if (int'(in_read_page) < PAGE_COUNT && int'(in_read_column) < PIXEL_WIDTH) begin
              want = frame_shadow[int'(in_read_page) * PIXEL_WIDTH + int'(in_read_column)];
            end
            expected_read_bytes.push_back(want);
          end
          default: ;
        endcase
      end
      if (end_check && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_read_bytes.size() != 0) begin
          report_mismatch($sformatf("%0d read results never arrived",
                                    expected_read_bytes.size()));
        end
      end
      pending_reads <= expected_read_bytes.size();
    end
  end

endmodule

// ===== tb/glyph_to_page_framebuffer_unit_test.sv =====
module glyph_to_page_framebuffer_unit_test;
  import gpfb_pkg::*;

  // reset clear, a clear plus the longest sender gap, the final settle: the
  // limit is a few times the longest of these
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 450;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_kind = KIND_NONE;
  logic [7:0] in_col_pos = '0;
  logic [5:0] in_row_pos = '0;
  logic [7:0] in_char_code = '0;
  logic [1:0] in_read_page = '0;
  logic [6:0] in_read_column = '0;
  logic       end_check = 1'b0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_read_byte;
  int         mismatch_count;
  int         pending_reads;
  int         idle_pct = 0;
  int         stall_cycles = 0;
  logic [7:0] last_col = '0;
  logic [5:0] last_row = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  glyph_to_page_framebuffer_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_col_pos     (in_col_pos),
    .in_row_pos     (in_row_pos),
    .in_char_code   (in_char_code),
    .in_read_page   (in_read_page),
    .in_read_column (in_read_column),
    .out_valid      (out_valid),
    .out_read_byte  (out_read_byte)
  );

  glyph_to_page_framebuffer_unit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_col_pos     (in_col_pos),
    .in_row_pos     (in_row_pos),
    .in_char_code   (in_char_code),
    .in_read_page   (in_read_page),
    .in_read_column (in_read_column),
    .out_valid      (out_valid),
    .out_read_byte  (out_read_byte),
    .end_check      (end_check),
    .mismatch_count (mismatch_count),
    .pending_reads  (pending_reads)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // returns once busy reads low after an edge, with start still high
  task automatic send_cmd(input kind_t kind, input logic [7:0] col, input logic [5:0] row,
                          input logic [7:0] code, input logic [1:0] page,
                          input logic [6:0] rcol);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
    in_kind        <= kind;
    in_col_pos     <= col;
    in_row_pos     <= row;
    in_char_code   <= code;
    in_read_page   <= page;
    in_read_column <= rcol;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_reads();
    start <= 1'b0;
    do @(posedge clk); while (pending_reads != 0);
  endtask

  // draws mostly on the panel, and reads, half of them around the last one drawn
  task automatic send_random_cmd(output bit counted);
    int         pick;
    logic [7:0] col;
    logic [5:0] row;
    logic [7:0] code;
    logic [1:0] page;
    logic [6:0] rcol;
    pick = $urandom_range(99);
    col  = 8'($urandom_range(255));
    row  = 6'($urandom_range(63));
    code = 8'($urandom_range(255));
    page = 2'($urandom_range(3));
    rcol = 7'($urandom_range(127));
    counted = 1'b1;
    if (pick < 48) begin
      if ($urandom_range(3) != 0) col = 8'($urandom_range(127));
      if ($urandom_range(3) != 0) row = 6'($urandom_range(31));
      if ($urandom_range(4) != 0) code = 8'($urandom_range(127, 32));
      last_col = col;
      last_row = row;
      send_cmd(KIND_DRAW, col, row, code, page, rcol);
    end else if (pick < 92) begin
      if ($urandom_range(1) == 0) begin
        rcol = 7'(last_col + 8'($urandom_range(4)));
        page = 2'((last_row + 6'($urandom_range(6))) >> 3);
      end
      send_cmd(KIND_READ, col, row, code, page, rcol);
    end else if (pick < 95) begin
      send_cmd(KIND_CLEAR, col, row, code, page, rcol);
    end else begin
      counted = 1'b0;
      send_cmd(KIND_NONE, col, row, code, page, rcol);
    end
  endtask

  initial begin
    int sent;
    bit counted;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset contents, clipping, substitution, arrow, unused kind, clear
    send_cmd(KIND_READ,  8'hFF, 6'h3F, 8'hFF, 2'd0, 7'd0);
    send_cmd(KIND_DRAW,  8'd0,   6'd0,  8'd65,  2'd3, 7'd127);
    send_cmd(KIND_READ,  8'hFF, 6'h3F, 8'hFF, 2'd0, 7'd0);
    send_cmd(KIND_READ,  8'h00, 6'h00, 8'h00, 2'd0, 7'd4);
    send_cmd(KIND_DRAW,  8'd125, 6'd3,  8'd87,  2'd0, 7'd0);
    send_cmd(KIND_READ,  8'h00, 6'h00, 8'h00, 2'd0, 7'd127);
    send_cmd(KIND_DRAW,  8'd255, 6'd63, 8'd255, 2'd3, 7'd127);
    send_cmd(KIND_DRAW,  8'd60,  6'd28, 8'd127, 2'd0, 7'd0);
    send_cmd(KIND_READ,  8'hFF, 6'h3F, 8'hFF, 2'd3, 7'd62);
    send_cmd(KIND_DRAW,  8'd20,  6'd5,  8'd0,   2'd0, 7'd0);
    send_cmd(KIND_READ,  8'h00, 6'h00, 8'h00, 2'd0, 7'd22);
    send_cmd(KIND_READ,  8'h00, 6'h00, 8'h00, 2'd1, 7'd22);
    send_cmd(KIND_DRAW,  8'd40,  6'd12, 8'd31,  2'd0, 7'd0);
    send_cmd(KIND_DRAW,  8'd48,  6'd12, 8'd128, 2'd0, 7'd0);
    send_cmd(KIND_READ,  8'h00, 6'h00, 8'h00, 2'd1, 7'd41);
    send_cmd(KIND_READ,  8'h00, 6'h00, 8'h00, 2'd1, 7'd49);
    send_cmd(KIND_DRAW,  8'd100, 6'd0,  8'd32,  2'd0, 7'd0);
    send_cmd(KIND_DRAW,  8'd127, 6'd31, 8'd126, 2'd0, 7'd0);
    send_cmd(KIND_READ,  8'hFF, 6'h3F, 8'hFF, 2'd3, 7'd127);
    send_cmd(KIND_NONE,  8'hFF, 6'h3F, 8'hFF, 2'd3, 7'd127);
    send_cmd(KIND_READ,  8'h00, 6'h00, 8'h00, 2'd0, 7'd0);
    send_cmd(KIND_CLEAR, 8'hFF, 6'h3F, 8'hFF, 2'd3, 7'd127);
    send_cmd(KIND_READ,  8'h00, 6'h00, 8'h00, 2'd0, 7'd0);
    send_cmd(KIND_READ,  8'h00, 6'h00, 8'h00, 2'd3, 7'd127);
    drain_reads();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 48 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_random_cmd(counted);
        if (counted) sent++;
        if ($urandom_range(99) == 0) drain_reads();
      end
      drain_reads();
    end

    // last command may be a clear: let it finish before closing the books
    repeat (600) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
